// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define SFD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Check that a condition never holds at a clock edge outside reset.
`define SFD_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`endif

// ===== src/sfd_pkg.sv =====
`timescale 1ns / 1ps

package sfd_pkg;

	// Framing bytes
	localparam logic [7:0] ESC_BYTE   = 8'h77;
	localparam logic [7:0] START_BYTE = 8'h78;
	localparam logic [7:0] END_BYTE   = 8'h79;

	// Escape codes following ESC_BYTE
	localparam logic [7:0] ESC_CODE_ESC   = 8'h01;
	localparam logic [7:0] ESC_CODE_START = 8'h02;
	localparam logic [7:0] ESC_CODE_END   = 8'h03;

	localparam logic [7:0] MAX_LEN_RESET = 8'd100;

	// Result queue depth: one entry draining plus two pushed by one item
	localparam int RQ_DEPTH = 3;

	typedef enum logic [2:0] {
		KIND_DATA  = 3'd0,
		KIND_GOOD  = 3'd1,
		KIND_BAD   = 3'd2,
		KIND_OVF   = 3'd3,
		KIND_EMPTY = 3'd4
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic [7:0] idx;
		logic       last;
	} res_t;

	typedef struct packed {
		logic       in_frame;
		logic       esc_pend;
		logic [7:0] run_xor;
		logic [7:0] dec_cnt;
	} sfd_state_t;

endpackage

// ===== src/sfd_decode.sv =====
`timescale 1ns / 1ps

module sfd_decode
	import sfd_pkg::*;
(
	input  sfd_state_t st,
	input  logic [7:0] in_byte,
	input  logic [7:0] max_len,
	output sfd_state_t st_n,
	output res_t       res0,
	output res_t       res1,
	output logic [1:0] n_res
);

	always_comb begin : decode_blk
		logic       f;
		logic       e;
		logic [7:0] x;
		logic [7:0] c;
		logic [7:0] d;
		logic       good_esc;
		logic       run_plain;
		logic       va;
		logic       vb;
		res_t       r_a;
		res_t       r_b;

		f         = st.in_frame;
		e         = st.esc_pend;
		x         = st.run_xor;
		c         = st.dec_cnt;
		r_a       = '0;
		r_b       = '0;
		va        = 1'b0;
		vb        = 1'b0;
		run_plain = 1'b1;
		good_esc  = (in_byte == ESC_CODE_ESC) || (in_byte == ESC_CODE_START) ||
			(in_byte == ESC_CODE_END);
		d         = ESC_BYTE;

		// Resolve a pending escape: valid code decodes, anything else gives a literal escape
		if (f && e) begin
			e = 1'b0;
			if (good_esc) begin
				d = ESC_BYTE + (in_byte - 8'd1);
			end
			va = 1'b1;
			if (c >= max_len) begin
				r_a.kind = KIND_OVF;
				r_a.idx  = c;
				f        = 1'b0;
			end else begin
				r_a.kind = KIND_DATA;
				r_a.data = d;
				r_a.idx  = c;
				x        = x ^ d;
				c        = c + 8'd1;
			end
			run_plain = !good_esc;
		end else begin
			e = 1'b0;
		end

		// Handle the byte as a plain byte
		if (run_plain) begin
			if (!f) begin
				if (in_byte == START_BYTE) begin
					f = 1'b1;
					e = 1'b0;
					x = '0;
					c = '0;
				end
			end else if (in_byte == ESC_BYTE) begin
				e = 1'b1;
			end else if (in_byte == END_BYTE) begin
				vb = 1'b1;
				if (c == 8'd0) begin
					r_b.kind = KIND_EMPTY;
				end else if (x == 8'd0) begin
					r_b.kind = KIND_GOOD;
				end else begin
					r_b.kind = KIND_BAD;
				end
				r_b.idx = c;
				f       = 1'b0;
				e       = 1'b0;
			end else begin
				vb = 1'b1;
				if (c >= max_len) begin
					r_b.kind = KIND_OVF;
					r_b.idx  = c;
					f        = 1'b0;
					e        = 1'b0;
				end else begin
					r_b.kind = KIND_DATA;
					r_b.data = in_byte;
					r_b.idx  = c;
					x        = x ^ in_byte;
					c        = c + 8'd1;
				end
			end
		end

		// Compact the results and mark the final one
		if (va) begin
			res0  = r_a;
			res1  = r_b;
			n_res = vb ? 2'd2 : 2'd1;
			if (vb) begin
				res1.last = 1'b1;
			end else begin
				res0.last = 1'b1;
			end
		end else begin
			res0      = r_b;
			res1      = '0;
			n_res     = vb ? 2'd1 : 2'd0;
			res0.last = 1'b1;
		end

		st_n.in_frame = f;
		st_n.esc_pend = e;
		st_n.run_xor  = x;
		st_n.dec_cnt  = c;
	end

endmodule

// ===== src/sfd_rq.sv =====
`timescale 1ns / 1ps

module sfd_rq
	import sfd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic [1:0] push_n,
	input  res_t       din0,
	input  res_t       din1,
	input  logic       pop,
	output res_t       head,
	output logic       not_empty,
	output logic       room
);

	res_t       ent_q [RQ_DEPTH];
	res_t       ent_n [RQ_DEPTH];
	logic [1:0] count_q;
	logic [1:0] count_n;
	logic [1:0] cnt_pop;

	assign head      = ent_q[0];
	assign not_empty = (count_q != 2'd0);
	assign room      = (count_q <= 2'd1);

	// Shift out the head on pop, then append new results behind the survivors
	always_comb begin
		for (int i = 0; i < RQ_DEPTH; i++) begin
			ent_n[i] = ent_q[i];
		end
		cnt_pop = count_q;
		if (pop) begin
			for (int i = 0; i < RQ_DEPTH - 1; i++) begin
				ent_n[i] = ent_q[i + 1];
			end
			cnt_pop = count_q - 2'd1;
		end
		count_n = cnt_pop;
		if (push) begin
			if (push_n != 2'd0) begin
				ent_n[cnt_pop] = din0;
			end
			if (push_n == 2'd2) begin
				ent_n[cnt_pop + 2'd1] = din1;
			end
			count_n = cnt_pop + push_n;
		end
	end

	// Hold result payloads
	always_ff @(posedge clk) begin
		for (int i = 0; i < RQ_DEPTH; i++) begin
			ent_q[i] <= ent_n[i];
		end
	end

	// Track fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_n;
		end
	end

endmodule

// ===== src/stuffed_frame_deframer.sv =====
`timescale 1ns / 1ps
// A result is decoded combinationally and registered in the result queue before it
// is output. Throughput: one input item per cycle while the queue has room; an item
// that yields two results (escape error followed by data, end or overflow) fills
// two of the three queue entries; the queue pops one result per cycle if not stalled.
// Reset (arst_n low, asynchronous): hunting for start, queue empty, max_len_q = 100.
`include "assert_macros.svh"

module stuffed_frame_deframer
	import sfd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] kind,
	output logic [7:0] data_byte,
	output logic [7:0] byte_index,
	output logic       last_of_run,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);

	sfd_state_t st_q;
	sfd_state_t st_n;
	logic [7:0] max_len_q;
	res_t       res0;
	res_t       res1;
	logic [1:0] n_res;
	res_t       head;
	logic       room;
	logic       in_acc;
	logic       pop;

	assign cfg_ready = 1'b1;
	assign in_stall  = !room;
	assign in_acc    = in_valid && !in_stall;
	assign pop       = out_valid && !out_stall;

	// Hold the frame length limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_len_q <= cfg_data;
		end
	end

	// Decode one byte against the current frame state
	sfd_decode u_decode (
		.st      (st_q),
		.in_byte (in_byte),
		.max_len (max_len_q),
		.st_n    (st_n),
		.res0    (res0),
		.res1    (res1),
		.n_res   (n_res)
	);

	// Advance frame state on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (in_acc) begin
			st_q <= st_n;
		end
	end

	// Queue results toward the output
	sfd_rq u_rq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_acc),
		.push_n    (n_res),
		.din0      (res0),
		.din1      (res1),
		.pop       (pop),
		.head      (head),
		.not_empty (out_valid),
		.room      (room)
	);

	assign kind        = head.kind;
	assign data_byte   = head.data;
	assign byte_index  = head.idx;
	assign last_of_run = head.last;

	`SFD_ASSERT(a_esc_in_frame, st_q.esc_pend |-> st_q.in_frame, "escape pending outside a frame")
	`SFD_ASSERT(a_state_hold, !in_acc |=> $stable(st_q), "frame state moved without an item")
	`SFD_ASSERT_NEVER(a_status_data, out_valid && (head.kind != KIND_DATA) && (head.data != 8'd0), "status result carries data")
	`SFD_ASSERT(a_hunt_quiet, (in_acc && !st_q.in_frame) |-> (n_res == 2'd0), "result while hunting")

endmodule
